// ===== hw/rtl/cll_pkg.sv =====
// Package: shared constants, operation codes and the link-table write struct for the list engine.
package cll_pkg;

    localparam int POOL_SLOTS = 16;
    localparam int SLOT_W     = $clog2(POOL_SLOTS);
    localparam int VALUE_W    = 32;
    localparam int STEP_W     = $clog2(POOL_SLOTS + 1);

    localparam logic [2:0] KIND_NEW    = 3'd0;
    localparam logic [2:0] KIND_APPEND = 3'd1;
    localparam logic [2:0] KIND_FIND   = 3'd2;
    localparam logic [2:0] KIND_DELETE = 3'd3;
    localparam logic [2:0] KIND_CLEAR  = 3'd4;
    localparam logic [2:0] KIND_EMPTY  = 3'd5;

    localparam logic [1:0] ST_OK  = 2'd0;
    localparam logic [1:0] ST_FULL = 2'd1;
    localparam logic [1:0] ST_BAD = 2'd2;

    typedef struct packed {
        logic              we;
        logic [SLOT_W-1:0] waddr;
        logic [SLOT_W-1:0] wdata;
    } link_wr_t;

endpackage

// ===== hw/rtl/cursor_linked_list_engine.sv =====
// Top level of the cursor linked-list engine: sequencer over a link table and a value RAM.
//
//  channel | valid     | stall     | word fields
//  --------+-----------+-----------+-------------------------------
//  in      | in_valid  | in_stall  | kind, list_handle, value
//  out     | out_valid | out_stall | position, hit, status
//
// One word is processed at a time. A bad handle, an unknown kind and is_empty go from
// S_IDLE straight to S_DONE; new_list first writes the new node's link in S_FIX1.
// append walks one node per cycle. find and delete spend S_WALK and S_CMP on each
// node for the registered read of the value RAM, and clear S_WALK and S_FIX1 for its
// two link writes, so delete is the longest operation.
// Reset restores the link table to its in-order free chain at once; the value RAM has
// no reset. The input is stalled only while an operation runs. A finished result moves
// into its own output register, so the next word can be taken while it waits; the
// sequencer holds in its last state only when a second result is ready behind it.
module cursor_linked_list_engine (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [2:0]                  kind,
    input  logic [3:0]                  list_handle,
    input  logic signed [31:0]          value,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [3:0]                  position,
    output logic                        hit,
    output logic [1:0]                  status
);

    localparam int SW = cll_pkg::SLOT_W;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_WALK  = 3'd1; // follow links, issue value read
    localparam logic [2:0] S_CMP   = 3'd2; // value read data valid
    localparam logic [2:0] S_FIX1  = 3'd3; // second link update
    localparam logic [2:0] S_FIX2  = 3'd4; // third link update
    localparam logic [2:0] S_DONE  = 3'd5;

    logic [2:0]              state_reg, state_next;
    logic [2:0]              kind_reg, kind_next;
    logic [31:0]             val_reg, val_next;
    logic [SW-1:0]           p_reg, p_next;     // current node
    logic [SW-1:0]           n_reg, n_next;     // node taken or examined
    logic [cll_pkg::STEP_W-1:0] steps_reg, steps_next;
    logic [SW-1:0]           pos_reg, pos_next;
    logic                    hit_reg, hit_next;
    logic [1:0]              st_reg, st_next;
    logic                    ov_reg, ov_next;
    logic [SW-1:0]           out_pos_reg;
    logic                    out_hit_reg;
    logic [1:0]              out_st_reg;
    logic                    load_out;

    cll_pkg::link_wr_t       lwr;
    logic [SW-1:0]           lraddr, lrdata, free_head;
    logic                    vwe;
    logic [SW-1:0]           vwaddr, vraddr;
    logic [31:0]             vrdata;

    cll_links u_links (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr        (lwr),
        .raddr     (lraddr),
        .rdata     (lrdata),
        .free_head (free_head)
    );

    cll_ram #(.WIDTH(32), .DEPTH(cll_pkg::POOL_SLOTS)) u_values (
        .clk   (clk),
        .we    (vwe),
        .waddr (vwaddr),
        .wdata (val_reg),
        .raddr (vraddr),
        .rdata (vrdata)
    );

    logic          accept;
    logic [SW-1:0] hnd;
    logic          bad_hnd;
    logic          walk_done;

    assign accept   = in_valid && !in_stall;
    assign in_stall = (state_reg != S_IDLE);
    assign hnd      = list_handle[SW-1:0];
    // Handles of zero or beyond the pool are rejected.
    assign bad_hnd  = (list_handle == '0) || (32'(list_handle) >= cll_pkg::POOL_SLOTS);
    assign walk_done = (steps_reg == cll_pkg::STEP_W'(cll_pkg::POOL_SLOTS));

    always_comb
    begin
        state_next = state_reg;
        kind_next  = kind_reg;
        val_next   = val_reg;
        p_next     = p_reg;
        n_next     = n_reg;
        steps_next = steps_reg;
        pos_next   = pos_reg;
        hit_next   = hit_reg;
        st_next    = st_reg;
        ov_next    = ov_reg;
        load_out   = 1'b0;
        lwr        = '0;
        lraddr     = p_reg;
        vwe        = 1'b0;
        vwaddr     = n_reg;
        vraddr     = n_reg;

        if (ov_reg && !out_stall)
        begin
            ov_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    kind_next  = kind;
                    val_next   = value;
                    steps_next = '0;
                    pos_next   = '0;
                    hit_next   = 1'b0;
                    st_next    = cll_pkg::ST_OK;
                    state_next = S_DONE;
                    if (kind > cll_pkg::KIND_EMPTY)
                    begin
                        state_next = S_DONE;
                    end
                    else if (kind != cll_pkg::KIND_NEW && bad_hnd)
                    begin
                        st_next = cll_pkg::ST_BAD;
                    end
                    else
                    begin
                        case (kind)
                            cll_pkg::KIND_NEW, cll_pkg::KIND_APPEND:
                            begin
                                if (free_head == '0)
                                begin
                                    st_next = cll_pkg::ST_FULL;
                                end
                                else
                                begin
                                    // Pop the free head: link[0] <= link[head].
                                    n_next     = free_head;
                                    lraddr     = free_head;
                                    lwr.we     = 1'b1;
                                    lwr.waddr  = '0;
                                    lwr.wdata  = lrdata;
                                    pos_next   = free_head;
                                    p_next     = hnd;
                                    state_next = (kind == cll_pkg::KIND_NEW) ? S_FIX1 : S_WALK;
                                end
                            end
                            cll_pkg::KIND_FIND:
                            begin
                                lraddr     = hnd;
                                n_next     = lrdata;
                                state_next = S_WALK;
                            end
                            cll_pkg::KIND_DELETE:
                            begin
                                p_next     = hnd;
                                lraddr     = hnd;
                                n_next     = lrdata;
                                state_next = S_WALK;
                            end
                            cll_pkg::KIND_CLEAR:
                            begin
                                lraddr     = hnd;
                                n_next     = lrdata;
                                lwr.we     = 1'b1;
                                lwr.waddr  = hnd;
                                lwr.wdata  = '0;
                                state_next = S_WALK;
                            end
                            default:
                            begin
                                lraddr   = hnd;
                                hit_next = (lrdata == '0);
                            end
                        endcase
                    end
                end
            end

            S_WALK:
            begin
                case (kind_reg)
                    cll_pkg::KIND_APPEND:
                    begin
                        // Walk to the tail from p; n holds the new node.
                        lraddr = p_reg;
                        if (lrdata != '0 && !walk_done)
                        begin
                            p_next     = lrdata;
                            steps_next = steps_reg + 1'b1;
                        end
                        else
                        begin
                            vwe        = 1'b1;
                            vwaddr     = n_reg;
                            lwr.we     = 1'b1;
                            lwr.waddr  = n_reg;
                            lwr.wdata  = lrdata;
                            state_next = S_FIX1;
                        end
                    end
                    cll_pkg::KIND_CLEAR:
                    begin
                        // Free node n: link[n] <= link[0], then link[0] <= n.
                        if (n_reg == '0 || walk_done)
                        begin
                            state_next = S_DONE;
                        end
                        else
                        begin
                            lraddr     = n_reg;
                            p_next     = lrdata;
                            lwr.we     = 1'b1;
                            lwr.waddr  = n_reg;
                            lwr.wdata  = free_head;
                            state_next = S_FIX1;
                        end
                    end
                    default:
                    begin
                        // find and delete: n is the candidate node.
                        if (n_reg == '0)
                        begin
                            state_next = S_DONE;
                        end
                        else
                        begin
                            vraddr     = n_reg;
                            state_next = S_CMP;
                        end
                    end
                endcase
            end

            S_CMP:
            begin
                lraddr = n_reg;
                if (vrdata == val_reg)
                begin
                    pos_next = n_reg;
                    hit_next = 1'b1;
                    if (kind_reg == cll_pkg::KIND_DELETE)
                    begin
                        // Unlink n from p, then push n onto the free list.
                        lwr.we     = 1'b1;
                        lwr.waddr  = p_reg;
                        lwr.wdata  = lrdata;
                        state_next = S_FIX1;
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
                else if (walk_done)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    p_next     = n_reg;
                    n_next     = lrdata;
                    steps_next = steps_reg + 1'b1;
                    state_next = S_WALK;
                end
            end

            S_FIX1:
            begin
                case (kind_reg)
                    cll_pkg::KIND_NEW:
                    begin
                        lwr.we     = 1'b1;
                        lwr.waddr  = n_reg;
                        lwr.wdata  = '0;
                        state_next = S_DONE;
                    end
                    cll_pkg::KIND_APPEND:
                    begin
                        lwr.we     = 1'b1;
                        lwr.waddr  = p_reg;
                        lwr.wdata  = n_reg;
                        state_next = S_DONE;
                    end
                    cll_pkg::KIND_CLEAR:
                    begin
                        lwr.we     = 1'b1;
                        lwr.waddr  = '0;
                        lwr.wdata  = n_reg;
                        n_next     = p_reg;
                        steps_next = steps_reg + 1'b1;
                        state_next = S_WALK;
                    end
                    default:
                    begin
                        lwr.we     = 1'b1;
                        lwr.waddr  = n_reg;
                        lwr.wdata  = free_head;
                        state_next = S_FIX2;
                    end
                endcase
            end

            S_FIX2:
            begin
                lwr.we     = 1'b1;
                lwr.waddr  = '0;
                lwr.wdata  = n_reg;
                state_next = S_DONE;
            end

            S_DONE:
            begin
                // The result moves out once the output register is empty or being taken.
                if (!ov_reg || !out_stall)
                begin
                    ov_next    = 1'b1;
                    load_out   = 1'b1;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg  <= kind_next;
        val_reg   <= val_next;
        p_reg     <= p_next;
        n_reg     <= n_next;
        steps_reg <= steps_next;
        pos_reg   <= pos_next;
        hit_reg   <= hit_next;
        st_reg    <= st_next;
        if (load_out)
        begin
            out_pos_reg <= pos_reg;
            out_hit_reg <= hit_reg;
            out_st_reg  <= st_reg;
        end
    end

    assign out_valid = ov_reg;
    assign position  = 4'(out_pos_reg);
    assign hit       = out_hit_reg;
    assign status    = out_st_reg;

    a_busy_stalls: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> in_stall)
        else $error("input taken while an operation is running");

    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg != S_IDLE))
        else $error("accepted word did not start an operation");

    a_walk_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> (steps_reg <= cll_pkg::STEP_W'(cll_pkg::POOL_SLOTS)))
        else $error("chain walk exceeded the pool size");

    a_status_legal: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (status != 2'd3))
        else $error("illegal status code");

    a_out_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable({position, hit, status})))
        else $error("stalled result word changed");

endmodule

// ===== hw/rtl/cll_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
module cll_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== hw/rtl/cll_links.sv =====
// Link table: flip-flop array with reset pattern, one write and two reads a cycle.
module cll_links (
    input  logic                       clk,
    input  logic                       rst_n,
    input  cll_pkg::link_wr_t          wr,
    input  logic [cll_pkg::SLOT_W-1:0] raddr,
    output logic [cll_pkg::SLOT_W-1:0] rdata,
    output logic [cll_pkg::SLOT_W-1:0] free_head
);

    logic [cll_pkg::SLOT_W-1:0] link_reg [cll_pkg::POOL_SLOTS];

    // Each slot links to the next one after reset; the last slot closes with zero.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < cll_pkg::POOL_SLOTS; i++)
            begin
                link_reg[i] <= (i + 1 < cll_pkg::POOL_SLOTS) ?
                               cll_pkg::SLOT_W'(i + 1) : '0;
            end
        end
        else if (wr.we)
        begin
            link_reg[wr.waddr] <= wr.wdata;
        end
    end

    assign rdata     = link_reg[raddr];
    assign free_head = link_reg[0];

endmodule

// ===== dv/cursor_linked_list_engine_test.sv =====
// Testbench for the cursor linked-list engine: directed and random operations checked by a scoreboard.
`timescale 1ns / 100ps

module cursor_linked_list_engine_test;

    // One expected answer of the engine.
    typedef struct {
        logic [3:0] pos;
        logic       hit;
        logic [1:0] st;
    } answer_t;

    // The scoreboard keeps its own copy of the node pool and predicts every answer.
    // Each word accepted on the input is run through that pool at once. The answer
    // waits in a queue until the matching word leaves the output.
    class list_scoreboard;
        logic [31:0] node_val[16];
        logic [3:0]  node_next[16];
        bit          written[16];
        answer_t     awaited[$];
        int          errors;
        int          checked;
        int          hits;
        int          fulls;
        int          bads;

        function new();
            for (int i = 0; i < 16; i++)
            begin
                node_next[i] = 4'((i + 1) % 16);
                written[i] = 0;
            end
            errors = 0;
            checked = 0;
            hits = 0;
            fulls = 0;
            bads = 0;
        endfunction

        function logic [3:0] pop_free();
            logic [3:0] p;
            p = node_next[0];
            if (p != 0)
                node_next[0] = node_next[p];
            return p;
        endfunction

        function void push_free(logic [3:0] p);
            node_next[p] = node_next[0];
            node_next[0] = p;
        endfunction

        // A find or a delete compares the value of every node after the handle. A node
        // that no append ever wrote has an undefined value in the engine, so such a
        // walk must not be started.
        function bit walk_is_defined(logic [3:0] h);
            logic [3:0] p;
            p = node_next[h];
            for (int s = 0; s <= 16; s++)
            begin
                if (p == 0)
                    return 1;
                if (!written[p])
                    return 0;
                p = node_next[p];
            end
            return 1;
        endfunction

        // Runs one operation on the pool copy and queues the answer it must give.
        function answer_t note_word(logic [2:0] k, logic [3:0] h, logic [31:0] v);
            answer_t    a;
            logic [3:0] p;
            logic [3:0] n;
            int         steps;
            a.pos = 0;
            a.hit = 0;
            a.st = cll_pkg::ST_OK;
            if (k >= cll_pkg::KIND_APPEND && k <= cll_pkg::KIND_EMPTY && h == 0)
                a.st = cll_pkg::ST_BAD;
            else if (k == cll_pkg::KIND_NEW)
            begin
                p = pop_free();
                if (p == 0)
                    a.st = cll_pkg::ST_FULL;
                else
                begin
                    node_next[p] = 0;
                    a.pos = p;
                end
            end
            else if (k == cll_pkg::KIND_APPEND)
            begin
                n = pop_free();
                if (n == 0)
                    a.st = cll_pkg::ST_FULL;
                else
                begin
                    // Walk to the tail, but never more than a pool's worth of steps.
                    p = h;
                    steps = 0;
                    while (p != 0 && node_next[p] != 0 && steps < 16)
                    begin
                        p = node_next[p];
                        steps++;
                    end
                    node_val[n] = v;
                    written[n] = 1;
                    node_next[n] = node_next[p];
                    node_next[p] = n;
                    a.pos = n;
                end
            end
            else if (k == cll_pkg::KIND_FIND)
            begin
                p = node_next[h];
                steps = 0;
                while (p != 0 && node_val[p] != v && steps < 16)
                begin
                    p = node_next[p];
                    steps++;
                end
                if (p != 0 && node_val[p] == v)
                begin
                    a.pos = p;
                    a.hit = 1;
                end
            end
            else if (k == cll_pkg::KIND_DELETE)
            begin
                p = h;
                steps = 0;
                while (node_next[p] != 0 && node_val[node_next[p]] != v && steps < 16)
                begin
                    p = node_next[p];
                    steps++;
                end
                n = node_next[p];
                if (n != 0 && node_val[n] == v)
                begin
                    node_next[p] = node_next[n];
                    push_free(n);
                    a.pos = n;
                    a.hit = 1;
                end
            end
            else if (k == cll_pkg::KIND_CLEAR)
            begin
                // The header stays; each node behind it returns to the free list.
                p = node_next[h];
                node_next[h] = 0;
                steps = 0;
                while (p != 0 && steps < 16)
                begin
                    n = node_next[p];
                    push_free(p);
                    p = n;
                    steps++;
                end
            end
            else if (k == cll_pkg::KIND_EMPTY)
                a.hit = (node_next[h] == 0);
            if (a.hit)
                hits++;
            if (a.st == cll_pkg::ST_FULL)
                fulls++;
            if (a.st == cll_pkg::ST_BAD)
                bads++;
            awaited.push_back(a);
            return a;
        endfunction

        function void check_result(logic [3:0] pos, logic hit, logic [1:0] st);
            answer_t a;
            if (awaited.size() == 0)
            begin
                $error("result word with no expected answer: position %0d hit %0d status %0d",
                       pos, hit, st);
                errors++;
                return;
            end
            a = awaited.pop_front();
            checked++;
            if (pos !== a.pos)
            begin
                $error("position: expected %0d, actual %0d", a.pos, pos);
                errors++;
            end
            if (hit !== a.hit)
            begin
                $error("hit: expected %0d, actual %0d", a.hit, hit);
                errors++;
            end
            if (st !== a.st)
            begin
                $error("status: expected %0d, actual %0d", a.st, st);
                errors++;
            end
        endfunction
    endclass

    localparam int RANDOM_WORDS = 1800;
    localparam int CYCLE_LIMIT  = 600000;

    logic              clk;
    logic              rst_n;
    logic              in_valid;
    logic              in_stall;
    logic [2:0]        kind;
    logic [3:0]        list_handle;
    logic signed [31:0] value;
    logic              out_valid;
    logic              out_stall;
    logic [3:0]        position;
    logic              hit;
    logic [1:0]        status;

    list_scoreboard board;
    logic [3:0]     headers[$];
    logic [31:0]    value_pool[8];
    bit             quiet;
    bit             sending_done;
    int             cycles = 0;

    cursor_linked_list_engine DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .kind        (kind),
        .list_handle (list_handle),
        .value       (value),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .position    (position),
        .hit         (hit),
        .status      (status)
    );

    initial
    begin
        clk = 0;
    end

    always #6 clk = ~clk;

    // A hung handshake ends the run here rather than running forever.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Offers one word and returns once the engine takes it. A valid from the previous
    // word stays high when no gap is drawn, so it is never lowered and raised at once.
    task automatic send_word(logic [2:0] k, logic [3:0] h, logic [31:0] v);
        int      gap;
        answer_t a;
        gap = quiet ? 0 : $urandom_range(0, 10);
        if (gap > 0)
        begin
            in_valid <= 0;
            repeat (gap) @(posedge clk);
        end
        // A find or delete whose walk would reach a never-written node becomes a
        // harmless emptiness query on the same handle.
        if ((k == cll_pkg::KIND_FIND || k == cll_pkg::KIND_DELETE) && h != 0 &&
            !board.walk_is_defined(h))
            k = cll_pkg::KIND_EMPTY;
        kind <= k;
        list_handle <= h;
        value <= v;
        in_valid <= 1;
        do
            @(posedge clk);
        while (in_stall);
        a = board.note_word(k, h, v);
        if (k == cll_pkg::KIND_NEW && a.st == cll_pkg::ST_OK)
            headers.push_back(a.pos);
    endtask

    function automatic logic [31:0] pick_value();
        if ($urandom_range(0, 9) < 8)
            return value_pool[$urandom_range(0, 7)];
        return $urandom();
    endfunction

    function automatic logic [3:0] pick_handle();
        if (headers.size() > 0 && $urandom_range(0, 9) < 8)
            return headers[$urandom_range(0, headers.size() - 1)];
        return 4'($urandom_range(0, 15));
    endfunction

    // The receiving side: a fresh stall length for every result word, none in quiet spells.
    initial
    begin
        int n;
        out_stall = 1;
        @(posedge rst_n);
        forever
        begin
            n = quiet ? 0 : $urandom_range(0, 10);
            if (n > 0)
            begin
                out_stall <= 1;
                repeat (n) @(posedge clk);
            end
            out_stall <= 0;
            do
                @(posedge clk);
            while (!out_valid);
            board.check_result(position, hit, status);
        end
    end

    initial
    begin
        logic [3:0] h;
        int         r;
        int         waited;
        board = new();
        quiet = 0;
        sending_done = 0;
        value_pool = '{32'h0, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                       32'h5, 32'hA5A5_5A5A, 32'h1234_5678, 32'hFFFF_FFFE};
        rst_n = 0;
        in_valid = 0;
        kind = cll_pkg::KIND_NEW;
        list_handle = 0;
        value = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // Directed part. A handle of zero is refused for every kind that takes one,
        // and the two unused kinds must answer with all fields zero.
        for (int k = cll_pkg::KIND_APPEND; k <= cll_pkg::KIND_EMPTY; k++)
            send_word(3'(k), 4'd0, 32'h7FFF_FFFF);
        send_word(3'd6, 4'd15, 32'hFFFF_FFFF);
        send_word(3'd7, 4'd3, 32'h8000_0000);
        send_word(cll_pkg::KIND_NEW, 4'd15, 32'h0);
        send_word(cll_pkg::KIND_EMPTY, headers[0], 32'h0);
        send_word(cll_pkg::KIND_APPEND, headers[0], 32'h8000_0000);
        send_word(cll_pkg::KIND_APPEND, headers[0], 32'h7FFF_FFFF);
        send_word(cll_pkg::KIND_APPEND, headers[0], 32'hFFFF_FFFF);
        send_word(cll_pkg::KIND_FIND, headers[0], 32'h7FFF_FFFF);
        send_word(cll_pkg::KIND_FIND, headers[0], 32'h0);
        send_word(cll_pkg::KIND_DELETE, headers[0], 32'h8000_0000);
        send_word(cll_pkg::KIND_DELETE, headers[0], 32'h1);
        // Fill the pool so that both new_list and append run out of space.
        repeat (12) send_word(cll_pkg::KIND_APPEND, headers[0], $urandom());
        send_word(cll_pkg::KIND_NEW, 4'd0, 32'h0);
        send_word(cll_pkg::KIND_APPEND, headers[0], 32'h0);
        send_word(cll_pkg::KIND_CLEAR, headers[0], 32'h0);
        send_word(cll_pkg::KIND_EMPTY, headers[0], 32'h0);
        send_word(cll_pkg::KIND_APPEND, 4'd15, 32'h0);

        // Random part: mostly well-formed traffic on live lists, with some raw handles
        // that run operations on free chains and inner nodes.
        for (int i = 0; i < RANDOM_WORDS; i++)
        begin
            if (i % 150 == 0)
                quiet = ($urandom_range(0, 3) == 0);
            r = $urandom_range(0, 99);
            h = pick_handle();
            if (r < 10)
                send_word(cll_pkg::KIND_NEW, 4'($urandom()), pick_value());
            else if (r < 42)
                send_word(cll_pkg::KIND_APPEND, h, pick_value());
            else if (r < 60)
                send_word(cll_pkg::KIND_FIND, h, pick_value());
            else if (r < 76)
                send_word(cll_pkg::KIND_DELETE, h, pick_value());
            else if (r < 83)
                send_word(cll_pkg::KIND_CLEAR, h, pick_value());
            else if (r < 93)
                send_word(cll_pkg::KIND_EMPTY, h, $urandom());
            else if (r < 97)
                send_word(3'($urandom_range(6, 7)), 4'($urandom()), $urandom());
            else
                send_word(3'($urandom_range(1, 5)), 4'd0, $urandom());
        end
        in_valid <= 0;
        sending_done = 1;

        waited = 0;
        while (board.awaited.size() > 0 && waited < 20000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (40) @(posedge clk);

        $display("Checked %0d result words: %0d hits, %0d out of space, %0d bad handles.",
                 board.checked, board.hits, board.fulls, board.bads);
        $display("Covered every kind, unused kinds, handle zero and wandering handles.");
        if (board.errors == 0 && board.awaited.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ===== cursor_linked_list_engine.f =====
hw/rtl/cll_pkg.sv
hw/rtl/cll_ram.sv
hw/rtl/cll_links.sv
hw/rtl/cursor_linked_list_engine.sv
dv/cursor_linked_list_engine_test.sv
